@@ hdl/bfhs_pkg.sv @@
// shared types and constants for the back/forward history stacks
// no dependencies; imported by the stack, controller and top level

package bfhs_pkg;

    localparam int OP_BITS = 3;

    // operation codes carried in the low bits of the input item
    typedef enum logic [OP_BITS-1:0] {
        OP_VISIT        = 3'd0,
        OP_BACK         = 3'd1,
        OP_FORWARD      = 3'd2,
        OP_REMOVE       = 3'd3,
        OP_DROP_BACK    = 3'd4,
        OP_DROP_FORWARD = 3'd5,
        OP_QUERY        = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PURGE,
        ST_TOPS,
        ST_DONE
    } state_t;

    // one-cycle command to a stack
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
        logic purge;
        logic top_rd;
    } stk_cmd_t;

endpackage

@@ hdl/bfhs_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module bfhs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/bfhs_stack.sv @@
// one bounded stack of page ids: circular buffer in a ram, count, base and purge walker
// depends on bfhs_pkg and bfhs_ram

module bfhs_stack
    import bfhs_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64,
    parameter int PAGE_ID_BITS  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  stk_cmd_t                           cmd,
    input  logic [PAGE_ID_BITS-1:0]            id,
    output logic                               busy,
    output logic [$clog2(HISTORY_DEPTH+1)-1:0] count,
    output logic [PAGE_ID_BITS-1:0]            top
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_SUM = (AW + 1)'(HISTORY_DEPTH);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(HISTORY_DEPTH);

    // logical position to ram address, wrapping round the buffer
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [AW-1:0] i);
        logic [AW:0] s;
        s = {1'b0, b} + {1'b0, i};
        if (s >= DEPTH_SUM)
        begin
            s = s - DEPTH_SUM;
        end
        return s[AW-1:0];
    endfunction

    logic [CW-1:0]           count_reg, count_next;
    logic [AW-1:0]           base_reg, base_next;
    logic                    purging_reg, purging_next;
    logic [CW-1:0]           rd_idx_reg, rd_idx_next;
    logic [CW-1:0]           wr_idx_reg, wr_idx_next;
    logic                    pend_reg, pend_next;
    logic [PAGE_ID_BITS-1:0] match_id_reg, match_id_next;
    logic [CW-1:0]           count_m1;

    logic                    we;
    logic [AW-1:0]           waddr;
    logic [PAGE_ID_BITS-1:0] wdata;
    logic                    re;
    logic [AW-1:0]           raddr;
    logic [PAGE_ID_BITS-1:0] rdata;

    bfhs_ram #(
        .WIDTH (PAGE_ID_BITS),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign count_m1 = count_reg - CW'(1);

    always_comb
    begin
        count_next    = count_reg;
        base_next     = base_reg;
        purging_next  = purging_reg;
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        pend_next     = pend_reg;
        match_id_next = match_id_reg;
        we            = 1'b0;
        waddr         = phys(base_reg, wr_idx_reg[AW-1:0]);
        wdata         = rdata;
        re            = 1'b0;
        raddr         = phys(base_reg, rd_idx_reg[AW-1:0]);

        if (purging_reg)
        begin
            // read walker one entry ahead of the compacting writer
            pend_next = 1'b0;
            if (rd_idx_reg < count_reg)
            begin
                re          = 1'b1;
                rd_idx_next = rd_idx_reg + CW'(1);
                pend_next   = 1'b1;
            end
            if (pend_reg && (rdata != match_id_reg))
            begin
                we          = 1'b1;
                wr_idx_next = wr_idx_reg + CW'(1);
            end
            if (!(rd_idx_reg < count_reg) && !pend_reg)
            begin
                purging_next = 1'b0;
                count_next   = wr_idx_reg;
            end
        end
        else
        begin
            if (cmd.push)
            begin
                we    = 1'b1;
                wdata = id;
                if (count_reg == DEPTH_CNT)
                begin
                    // full: overwrite the oldest and move the base on
                    waddr     = base_reg;
                    base_next = phys(base_reg, AW'(1));
                end
                else
                begin
                    waddr      = phys(base_reg, count_reg[AW-1:0]);
                    count_next = count_reg + CW'(1);
                end
            end
            if (cmd.pop && (count_reg != '0))
            begin
                count_next = count_m1;
            end
            if (cmd.clear)
            begin
                count_next = '0;
            end
            if (cmd.purge)
            begin
                purging_next  = 1'b1;
                rd_idx_next   = '0;
                wr_idx_next   = '0;
                pend_next     = 1'b0;
                match_id_next = id;
            end
            if (cmd.top_rd)
            begin
                re    = 1'b1;
                raddr = phys(base_reg, count_m1[AW-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            base_reg    <= '0;
            purging_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            base_reg    <= base_next;
            purging_reg <= purging_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        wr_idx_reg   <= wr_idx_next;
        match_id_reg <= match_id_next;
    end

    assign busy  = purging_reg;
    assign count = count_reg;
    assign top   = (count_reg != '0) ? rdata : '0;

endmodule

@@ hdl/bfhs_ctrl.sv @@
// sequencer for the history stacks: input capture, operation decode, result register
// depends on bfhs_pkg

module bfhs_ctrl
    import bfhs_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64,
    parameter int PAGE_ID_BITS  = 16
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              s_tvalid,
    output logic                                              s_tready,
    input  logic [((OP_BITS+2*PAGE_ID_BITS+7)/8)*8-1:0]       s_tdata,
    output logic                                              m_tvalid,
    input  logic                                              m_tready,
    output logic [((1+3*PAGE_ID_BITS+2*$clog2(HISTORY_DEPTH+1)+7)/8)*8-1:0] m_tdata,
    output stk_cmd_t                                          back_cmd,
    output stk_cmd_t                                          fwd_cmd,
    output logic [PAGE_ID_BITS-1:0]                           stk_id,
    input  logic                                              back_busy,
    input  logic                                              fwd_busy,
    input  logic [$clog2(HISTORY_DEPTH+1)-1:0]                back_count,
    input  logic [$clog2(HISTORY_DEPTH+1)-1:0]                fwd_count,
    input  logic [PAGE_ID_BITS-1:0]                           back_top,
    input  logic [PAGE_ID_BITS-1:0]                           fwd_top
);

    localparam int P     = PAGE_ID_BITS;
    localparam int CW    = $clog2(HISTORY_DEPTH + 1);
    localparam int OUT_W = ((1 + 3 * P + 2 * CW + 7) / 8) * 8;

    state_t         state_reg, state_next;
    op_t            op_reg;
    logic [P-1:0]   page_reg;
    logic [P-1:0]   to_reg;
    logic           tgt_valid_reg, tgt_valid_next;
    logic [P-1:0]   tgt_page_reg, tgt_page_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_load;
    logic           out_target_valid_reg;
    logic [P-1:0]   out_target_page_reg;
    logic [P-1:0]   out_back_top_reg;
    logic [P-1:0]   out_fwd_top_reg;
    logic [CW-1:0]  out_back_depth_reg;
    logic [CW-1:0]  out_fwd_depth_reg;
    logic           accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign stk_id   = page_reg;

    always_comb
    begin
        state_next     = state_reg;
        tgt_valid_next = tgt_valid_reg;
        tgt_page_next  = tgt_page_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_load       = 1'b0;
        back_cmd       = '0;
        fwd_cmd        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                tgt_valid_next = 1'b0;
                tgt_page_next  = '0;
                state_next     = ST_TOPS;
                unique case (op_reg)
                    OP_VISIT:
                    begin
                        if ((page_reg != '0) && (to_reg != '0) && (page_reg != to_reg))
                        begin
                            back_cmd.push = 1'b1;
                            fwd_cmd.clear = 1'b1;
                        end
                    end
                    OP_BACK:
                    begin
                        if (back_count != '0)
                        begin
                            // the cached top from the previous result is the target
                            tgt_valid_next = 1'b1;
                            tgt_page_next  = out_back_top_reg;
                            back_cmd.pop   = 1'b1;
                            fwd_cmd.push   = (page_reg != '0);
                        end
                    end
                    OP_FORWARD:
                    begin
                        if (fwd_count != '0)
                        begin
                            tgt_valid_next = 1'b1;
                            tgt_page_next  = out_fwd_top_reg;
                            fwd_cmd.pop    = 1'b1;
                            back_cmd.push  = (page_reg != '0);
                        end
                    end
                    OP_REMOVE:
                    begin
                        back_cmd.purge = 1'b1;
                        fwd_cmd.purge  = 1'b1;
                        state_next     = ST_PURGE;
                    end
                    OP_DROP_BACK:
                    begin
                        back_cmd.pop = 1'b1;
                    end
                    OP_DROP_FORWARD:
                    begin
                        fwd_cmd.pop = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_PURGE:
            begin
                if (!back_busy && !fwd_busy)
                begin
                    state_next = ST_TOPS;
                end
            end
            ST_TOPS:
            begin
                back_cmd.top_rd = 1'b1;
                fwd_cmd.top_rd  = 1'b1;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                // read data stays put until the result register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(s_tdata[OP_BITS-1:0]);
            page_reg <= s_tdata[OP_BITS +: P];
            to_reg   <= s_tdata[OP_BITS + P +: P];
        end
        tgt_valid_reg <= tgt_valid_next;
        tgt_page_reg  <= tgt_page_next;
        if (out_load)
        begin
            out_target_valid_reg <= tgt_valid_reg;
            out_target_page_reg  <= tgt_page_reg;
            out_back_top_reg     <= back_top;
            out_fwd_top_reg      <= fwd_top;
            out_back_depth_reg   <= back_count;
            out_fwd_depth_reg    <= fwd_count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_fwd_depth_reg, out_back_depth_reg, out_fwd_top_reg,
                              out_back_top_reg, out_target_page_reg, out_target_valid_reg});

endmodule

@@ hdl/back_forward_history_stacks.sv @@
// top level of the back/forward navigation history: two page-id stacks and their sequencer
// depends on bfhs_pkg, bfhs_ctrl, bfhs_stack (and through it bfhs_ram)

// Keeps a back stack and a forward stack of page ids, each HISTORY_DEPTH deep, with id 0
// meaning no page. Every accepted item yields exactly one result item carrying the page
// returned by back/forward (if any), both stack tops and both depths. Each stack is a
// circular buffer in its own ram with a registered read; a push onto a full stack
// overwrites the oldest entry by moving the buffer base, so a push is a single ram write
// and a pop only lowers the count. Visit, back, forward, drop and query items pass from
// acceptance to the result register through execute, top read and capture. Remove page
// walks both stacks in parallel, reading one entry a cycle and writing the survivors back
// compacted behind the read pointer; that walk over the ram sets how long a remove takes.
// A new item is taken only once the previous one has reached the result register, which
// then waits for the sink independently.
// No clearing pass is needed after reset: only entries below a stack's depth are read.

module back_forward_history_stacks
    import bfhs_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64,
    parameter int PAGE_ID_BITS  = 16
) (
    input  logic clk,
    input  logic rst_n,
    // operation, page_id, to_page_id (lowest bits first), zero filled to whole bytes
    input  logic                                                s_tvalid,
    output logic                                                s_tready,
    input  logic [((OP_BITS+2*PAGE_ID_BITS+7)/8)*8-1:0]         s_tdata,
    // target_valid, target_page, back_top, forward_top, back_depth, forward_depth
    // (lowest bits first), zero filled to whole bytes
    output logic                                                m_tvalid,
    input  logic                                                m_tready,
    output logic [((1+3*PAGE_ID_BITS+2*$clog2(HISTORY_DEPTH+1)+7)/8)*8-1:0] m_tdata
);

    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    stk_cmd_t                back_cmd;
    stk_cmd_t                fwd_cmd;
    logic [PAGE_ID_BITS-1:0] stk_id;
    logic                    back_busy;
    logic                    fwd_busy;
    logic [CW-1:0]           back_count;
    logic [CW-1:0]           fwd_count;
    logic [PAGE_ID_BITS-1:0] back_top;
    logic [PAGE_ID_BITS-1:0] fwd_top;

    // decode, sequencing and result register
    bfhs_ctrl #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PAGE_ID_BITS  (PAGE_ID_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .back_cmd   (back_cmd),
        .fwd_cmd    (fwd_cmd),
        .stk_id     (stk_id),
        .back_busy  (back_busy),
        .fwd_busy   (fwd_busy),
        .back_count (back_count),
        .fwd_count  (fwd_count),
        .back_top   (back_top),
        .fwd_top    (fwd_top)
    );

    // back stack: pages left behind, newest on top
    bfhs_stack #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PAGE_ID_BITS  (PAGE_ID_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (back_cmd),
        .id    (stk_id),
        .busy  (back_busy),
        .count (back_count),
        .top   (back_top)
    );

    // forward stack: pages stepped back from, cleared by a new visit
    bfhs_stack #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PAGE_ID_BITS  (PAGE_ID_BITS)
    ) u_fwd (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (fwd_cmd),
        .id    (stk_id),
        .busy  (fwd_busy),
        .count (fwd_count),
        .top   (fwd_top)
    );

endmodule
